// File: src/snrs_pkg.sv
// ----------------------------------------------------------------------------
// snrs_pkg
// Types, codes and constants of the safeguarded Newton root step unit.
// ----------------------------------------------------------------------------
package snrs_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int TOL_W      = 31;
	localparam int WALL_W     = 16;
	localparam int CNT_W      = 16;
	localparam int IDX_W      = 2;
	localparam int QUO_W      = DATA_W + FRAC_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	localparam logic [TOL_W-1:0]  X_TOL_RESET = TOL_W'(2);
	localparam logic [TOL_W-1:0]  F_TOL_RESET = TOL_W'(1);
	localparam logic [WALL_W-1:0] WALL_RESET  = WALL_W'(7);

	localparam logic [IDX_W-1:0] REG_X_TOL = 2'd0;
	localparam logic [IDX_W-1:0] REG_F_TOL = 2'd1;
	localparam logic [IDX_W-1:0] REG_WALL  = 2'd2;

	typedef enum logic [1:0] {
		STATUS_EVAL  = 2'd0,
		STATUS_FTOL  = 2'd1,
		STATUS_XTOL  = 2'd2,
		STATUS_ERROR = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_TEST,
		ST_WIDTH,
		ST_DIVIDE,
		ST_STEP,
		ST_NEAR,
		ST_GUARD,
		ST_EMIT
	} state_t;

endpackage

// File: src/safeguarded_newton_root_step_unit.sv
// ----------------------------------------------------------------------------
// safeguarded_newton_root_step_unit
// Newton root step with bisection safeguard, signed Q16.16.
// Input channel in_valid/in_ready: kind 0 starts a search on a bracket,
// kind 1 returns f and slope at the last requested x. Every start and every
// evaluation during a search gives one result on out_valid/out_ready; an
// evaluation while no search runs is taken and dropped.
// A start passes ST_START and ST_EMIT. An evaluation that takes the Newton
// step passes ST_TEST, ST_WIDTH, ST_DIVIDE (the restoring divider, one
// quotient bit per cycle for a 48-bit quotient), ST_STEP, ST_NEAR, ST_GUARD
// and ST_EMIT. One that stops on f goes from ST_TEST to ST_EMIT, one that
// stops on width from ST_WIDTH, one with zero slope via ST_GUARD.
// One item at a time: in_ready is high only while idle.
// The result waits in an output register; if the receiver stalls, a newly
// finished result waits until that register is free.
// Reset clears the search state and counts and loads the default
// tolerances and wall factor; cfg_we writes the tolerance or wall register.
// ----------------------------------------------------------------------------
module safeguarded_newton_root_step_unit
	import snrs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] start_low,
	input  logic signed [DATA_W-1:0] start_high,
	input  logic signed [DATA_W-1:0] start_f_low,
	input  logic signed [DATA_W-1:0] start_f_high,
	input  logic signed [DATA_W-1:0] f_value,
	input  logic signed [DATA_W-1:0] slope,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] x_out,
	output logic signed [DATA_W-1:0] f_out,
	output logic signed [DATA_W-1:0] slope_out,
	output logic [CNT_W-1:0]         eval_count,
	output logic [CNT_W-1:0]         bisect_count,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [TOL_W-1:0]         cfg_data
);

	localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
	localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

	state_t state_q, state_d;

	logic [TOL_W-1:0]  x_tol_q, f_tol_q;
	logic [WALL_W-1:0] wall_q;

	logic signed [DATA_W-1:0] low_q, high_q, vlow_q, cur_x_q, res_x_q;
	logic [CNT_W-1:0]         evals_q, bisects_q;
	logic                     running_q;
	status_t                  res_status_q;

	logic signed [DATA_W-1:0] start_low_q, start_high_q, start_f_low_q, start_f_high_q;
	logic signed [DATA_W-1:0] f_q, slope_q;

	logic [DATA_W-1:0]     rem_q, dvs_q;
	logic [QUO_W-1:0]      quo_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  quo_neg_q;

	logic signed [DATA_W:0]   width_q, near_q;
	logic signed [DATA_W-1:0] xc_q;
	logic signed [49:0]       prod_q;

	logic in_take, emit_go, out_valid_q;

	// combinational datapath
	logic [DATA_W-1:0]        abs_f, abs_slope;
	logic                     f_tol_hit, f_to_high;
	logic signed [DATA_W:0]   sum_start, sum_br, width_now, d_lo, d_hi, near_now;
	logic                     start_err, start_swap, x_tol_hit;
	logic [DATA_W:0]          div_shift, div_diff;
	logic                     div_ge;
	logic signed [49:0]       x_ext, q_ext, x_new, prod_now, near_sh;
	logic signed [DATA_W-1:0] x_sat;
	logic                     fallback;

	assign abs_f     = f_q[DATA_W-1] ? DATA_W'(-f_q) : DATA_W'(f_q);
	assign abs_slope = slope_q[DATA_W-1] ? DATA_W'(-slope_q) : DATA_W'(slope_q);
	assign f_tol_hit = abs_f <= {1'b0, f_tol_q};
	assign f_to_high = f_q[DATA_W-1] != vlow_q[DATA_W-1];

	assign sum_start  = {start_low_q[DATA_W-1], start_low_q}
		+ {start_high_q[DATA_W-1], start_high_q};
	assign sum_br     = {low_q[DATA_W-1], low_q} + {high_q[DATA_W-1], high_q};
	assign start_err  = (start_f_low_q == '0) || (start_f_high_q == '0)
		|| (start_f_low_q[DATA_W-1] == start_f_high_q[DATA_W-1]);
	assign start_swap = start_low_q > start_high_q;

	assign width_now = {high_q[DATA_W-1], high_q} - {low_q[DATA_W-1], low_q};
	assign x_tol_hit = width_now < $signed({2'b00, x_tol_q});

	assign div_shift = {rem_q, quo_q[QUO_W-1]};
	assign div_ge    = div_shift >= {1'b0, dvs_q};
	assign div_diff  = div_shift - {1'b0, dvs_q};

	assign x_ext = 50'(cur_x_q);
	assign q_ext = $signed({2'b00, quo_q});
	assign x_new = quo_neg_q ? (x_ext + q_ext) : (x_ext - q_ext);

	always_comb begin
		if (x_new > SAT_MAX) begin
			x_sat = DATA_W'(SAT_MAX);
		end else if (x_new < SAT_MIN) begin
			x_sat = DATA_W'(SAT_MIN);
		end else begin
			x_sat = x_new[DATA_W-1:0];
		end
	end

	assign d_lo     = {xc_q[DATA_W-1], xc_q} - {low_q[DATA_W-1], low_q};
	assign d_hi     = {high_q[DATA_W-1], high_q} - {xc_q[DATA_W-1], xc_q};
	assign near_now = (d_hi < d_lo) ? d_hi : d_lo;
	assign prod_now = $signed({1'b0, wall_q}) * width_q;
	assign near_sh  = $signed({near_q[DATA_W], near_q, {FRAC_W{1'b0}}});
	assign fallback = (slope_q == '0) || (near_sh < prod_q);

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EMIT: begin
				emit_go = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign in_take = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (!kind) begin
						state_d = ST_START;
					end else if (running_q) begin
						state_d = ST_TEST;
					end
				end
			end
			ST_START: begin
				state_d = ST_EMIT;
			end
			ST_TEST: begin
				state_d = f_tol_hit ? ST_EMIT : ST_WIDTH;
			end
			ST_WIDTH: begin
				priority if (x_tol_hit) begin
					state_d = ST_EMIT;
				end else if (slope_q == '0) begin
					state_d = ST_GUARD;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (step_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				state_d = ST_NEAR;
			end
			ST_NEAR: begin
				state_d = ST_GUARD;
			end
			ST_GUARD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			evals_q     <= '0;
			bisects_q   <= '0;
			x_tol_q     <= X_TOL_RESET;
			f_tol_q     <= F_TOL_RESET;
			wall_q      <= WALL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_X_TOL: x_tol_q <= cfg_data;
					REG_F_TOL: f_tol_q <= cfg_data;
					REG_WALL:  wall_q  <= cfg_data[WALL_W-1:0];
					default:   ;
				endcase
			end
			if (state_q == ST_START) begin
				evals_q   <= '0;
				bisects_q <= '0;
				running_q <= !start_err;
			end
			if (state_q == ST_TEST) begin
				if (evals_q != '1) begin
					evals_q <= evals_q + 1'b1;
				end
				if (f_tol_hit) begin
					running_q <= 1'b0;
				end
			end
			if (state_q == ST_WIDTH && x_tol_hit) begin
				running_q <= 1'b0;
			end
			if (state_q == ST_GUARD && fallback && bisects_q != '1) begin
				bisects_q <= bisects_q + 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			start_low_q    <= start_low;
			start_high_q   <= start_high;
			start_f_low_q  <= start_f_low;
			start_f_high_q <= start_f_high;
			f_q            <= f_value;
			slope_q        <= slope;
		end
		unique case (state_q)
			ST_START: begin
				if (start_err) begin
					res_status_q <= STATUS_ERROR;
					res_x_q      <= '0;
				end else begin
					res_status_q <= STATUS_EVAL;
					res_x_q      <= sum_start[DATA_W:1];
					cur_x_q      <= sum_start[DATA_W:1];
					if (start_swap) begin
						low_q  <= start_high_q;
						high_q <= start_low_q;
						vlow_q <= start_f_high_q;
					end else begin
						low_q  <= start_low_q;
						high_q <= start_high_q;
						vlow_q <= start_f_low_q;
					end
				end
			end
			ST_TEST: begin
				res_status_q <= STATUS_FTOL;
				res_x_q      <= cur_x_q;
				if (!f_tol_hit) begin
					if (f_to_high) begin
						high_q <= cur_x_q;
					end else begin
						low_q  <= cur_x_q;
						vlow_q <= f_q;
					end
				end
			end
			ST_WIDTH: begin
				res_status_q <= STATUS_XTOL;
				width_q      <= width_now;
				rem_q        <= '0;
				quo_q        <= {abs_f, {FRAC_W{1'b0}}};
				dvs_q        <= abs_slope;
				step_q       <= '0;
				quo_neg_q    <= f_q[DATA_W-1] ^ slope_q[DATA_W-1];
			end
			ST_DIVIDE: begin
				step_q <= step_q + 1'b1;
				if (div_ge) begin
					rem_q <= div_diff[DATA_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[DATA_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_STEP: begin
				xc_q <= x_sat;
			end
			ST_NEAR: begin
				near_q <= near_now;
				prod_q <= prod_now;
			end
			ST_GUARD: begin
				res_status_q <= STATUS_EVAL;
				if (fallback) begin
					res_x_q <= sum_br[DATA_W:1];
					cur_x_q <= sum_br[DATA_W:1];
				end else begin
					res_x_q <= xc_q;
					cur_x_q <= xc_q;
				end
			end
			default: ;
		endcase
		if (emit_go) begin
			status       <= res_status_q;
			x_out        <= res_x_q;
			eval_count   <= evals_q;
			bisect_count <= bisects_q;
			if (res_status_q == STATUS_FTOL || res_status_q == STATUS_XTOL) begin
				f_out     <= f_q;
				slope_out <= slope_q;
			end else begin
				f_out     <= '0;
				slope_out <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> step_q < STEP_CNT_W'(DIV_STEPS))
		else $error("divider step count out of range");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> !in_ready)
		else $error("start transfer did not make the unit busy");

	a_bracket_order: assert property (@(posedge clk) disable iff (!arst_n)
		running_q && state_q == ST_IDLE |-> low_q <= high_q)
		else $error("bracket ends out of order");
`endif

endmodule
